### design/sliding_window_mean_stddev_macros.svh
// assertion macros for the sliding window mean and deviation checker
// needs clk and rst in the scope where the macros are used
`ifndef SLIDING_WINDOW_MEAN_STDDEV_MACROS_SVH
`define SLIDING_WINDOW_MEAN_STDDEV_MACROS_SVH

// same-cycle implication
`define SWMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SWMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/swms_pkg.sv
// shared constants, command codes and sequencer states for the
// sliding window mean and deviation block; no dependencies
package swms_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int SUM_W       = 23;
  localparam int OUT_W       = 24;
  localparam int ACC_W       = 55;
  localparam int MEAN_W      = 31;
  localparam int STEP_W      = 6;
  localparam int SQRT_STEPS  = 28;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_TEST  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVICT,
    S_STORE,
    S_MEAN_LOAD,
    S_MEAN_DIV,
    S_WALK_RD,
    S_WALK_SQ,
    S_WALK_ACC,
    S_VAR_LOAD,
    S_VAR_DIV,
    S_SQRT_LOAD,
    S_SQRT,
    S_OUT
  } state_t;

endpackage

### design/sliding_window_mean_stddev.sv
// add: an evict state first once the window is full, then a 31-step mean divide, a square
// and an accumulate state per stored sample, a 55-step variance divide and a 28-step
// square root, all on one shared restoring divider and one square root step unit.
// test: mean divide only (none when empty); clear and unused go straight to the result;
// a request is taken the cycle after the result registers, one at a time, later if stalled.
// synchronous reset: empty window, window size 64, last mean and deviation zero; store kept.
module sliding_window_mean_stddev (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [swms_pkg::CNT_W-1:0] cfg_data,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [15:0]                s_tdata,   // sample[15:0]
  input  logic [1:0]                 s_tuser,   // command[1:0]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [55:0]                m_tdata    // mean_q8[23:0], dev_q8[47:24], count[54:48]
);
  import swms_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0]              wsize, held, remaining;
  logic [IDX_W-1:0]              oldest, addr;
  logic signed [SUM_W-1:0]       sum;
  cmd_t                          cmd;
  logic signed [SAMPLE_BITS-1:0] smp, rd_data;
  logic                          full;
  logic [SAMPLE_BITS-1:0]        mem [WINDOW_MAX];

  logic signed [OUT_W-1:0] last_mean, res_mean;
  logic [OUT_W-1:0]        last_dev, res_dev;

  // shared divider
  logic [ACC_W-1:0]  dq;
  logic [CNT_W-1:0]  drem, ddiv;
  logic              dneg;
  logic [STEP_W-1:0] step, dlast;
  logic [CNT_W:0]    trial;
  logic              ge;
  logic [CNT_W-1:0]  rem_next;

  logic [ACC_W-1:0] acc;
  logic [49:0]      sq;
  logic [ACC_W:0]   sx, sres, sbit, st;

  logic             out_valid;
  logic [55:0]      out_data;

  logic                    accept, cfg_full;
  logic [CNT_W:0]          pos_sum;
  logic [IDX_W-1:0]        pos_nf, addr_inc, pos_inc;
  logic signed [OUT_W-1:0] num, mag;
  logic signed [25:0]      s_scaled, mean_ext, dval;
  logic [25:0]             ad;
  logic [OUT_W-1:0]        qm;
  logic [CNT_W-1:0]        cfg_clamped;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  assign cfg_full = (held >= wsize);
  assign pos_sum  = {2'b0, oldest} + {1'b0, held};
  assign pos_nf   = (pos_sum >= {1'b0, wsize}) ? IDX_W'(pos_sum - {1'b0, wsize})
                                                : IDX_W'(pos_sum);
  assign addr_inc = (({1'b0, addr} + 1'b1) == wsize) ? '0 : addr + 1'b1;
  assign pos_inc  = addr_inc;

  assign trial    = {drem, dq[ACC_W-1]};
  assign ge       = (trial >= {1'b0, ddiv});
  assign rem_next = ge ? CNT_W'(trial - {1'b0, ddiv}) : CNT_W'(trial);

  assign num = (cmd == CMD_TEST) ? (OUT_W'(sum) + OUT_W'(smp)) : OUT_W'(sum);
  assign mag = num[OUT_W-1] ? -num : num;
  assign qm  = dq[OUT_W-1:0];

  assign s_scaled = {{2{rd_data[15]}}, rd_data, 8'b0};
  assign mean_ext = {{2{last_mean[OUT_W-1]}}, last_mean};
  assign dval     = s_scaled - mean_ext;
  assign ad       = dval[25] ? 26'(-dval) : 26'(dval);
  assign st       = sres + sbit;

  assign cfg_clamped = (cfg_data == '0) ? CNT_W'(1) :
                       (cfg_data > CNT_W'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX) : cfg_data;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd_t'(s_tuser))
            CMD_ADD:  state_next = cfg_full ? S_EVICT : S_STORE;
            CMD_TEST: state_next = (held == '0) ? S_OUT : S_MEAN_LOAD;
            default:  state_next = S_OUT;
          endcase
        end
      end
      S_EVICT:     state_next = S_STORE;
      S_STORE:     state_next = S_MEAN_LOAD;
      S_MEAN_LOAD: state_next = S_MEAN_DIV;
      S_MEAN_DIV: begin
        if (step == dlast) state_next = (cmd == CMD_TEST) ? S_OUT : S_WALK_RD;
      end
      S_WALK_RD:   state_next = S_WALK_SQ;
      S_WALK_SQ:   state_next = S_WALK_ACC;
      S_WALK_ACC:  state_next = (remaining != '0) ? S_WALK_SQ : S_VAR_LOAD;
      S_VAR_LOAD:  state_next = S_VAR_DIV;
      S_VAR_DIV: begin
        if (step == dlast) state_next = S_SQRT_LOAD;
      end
      S_SQRT_LOAD: state_next = S_SQRT;
      S_SQRT: begin
        if (step == STEP_W'(SQRT_STEPS - 1)) state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || m_tready) state_next = S_IDLE;
      end
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_STORE) begin
      mem[addr] <= smp;
    end
    rd_data <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wsize     <= CNT_W'(WINDOW_MAX);
      held      <= '0;
      oldest    <= '0;
      sum       <= '0;
      last_mean <= '0;
      last_dev  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && m_tready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        wsize  <= cfg_clamped;
        held   <= '0;
        oldest <= '0;
        sum    <= '0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cmd  <= cmd_t'(s_tuser);
            smp  <= s_tdata;
            full <= cfg_full;
            addr <= cfg_full ? oldest : pos_nf;
            case (cmd_t'(s_tuser))
              CMD_TEST: begin
                res_mean <= {s_tdata, 8'b0};
                res_dev  <= last_dev;
              end
              CMD_CLEAR: begin
                held      <= '0;
                oldest    <= '0;
                sum       <= '0;
                last_mean <= '0;
                last_dev  <= '0;
                res_mean  <= '0;
                res_dev   <= '0;
              end
              default: begin
                res_mean <= last_mean;
                res_dev  <= last_dev;
              end
            endcase
          end
        end
        S_STORE: begin
          if (full) begin
            sum    <= sum - SUM_W'(rd_data) + SUM_W'(smp);
            oldest <= pos_inc;
          end else begin
            sum  <= sum + SUM_W'(smp);
            held <= held + 1'b1;
          end
        end
        S_MEAN_LOAD: begin
          dq    <= {mag[MEAN_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}, {(ACC_W-MEAN_W){1'b0}}};
          drem  <= '0;
          ddiv  <= (cmd == CMD_TEST) ? held + 1'b1 : held;
          dneg  <= num[OUT_W-1];
          step  <= '0;
          dlast <= STEP_W'(MEAN_W - 1);
        end
        S_MEAN_DIV, S_VAR_DIV: begin
          dq   <= {dq[ACC_W-2:0], ge};
          drem <= rem_next;
          step <= step + 1'b1;
          if (state == S_MEAN_DIV && step == dlast) begin
            // final quotient bit lands here
            res_mean <= dneg ? -OUT_W'({qm[OUT_W-2:0], ge}) : OUT_W'({qm[OUT_W-2:0], ge});
            res_dev  <= last_dev;
            if (cmd != CMD_TEST) begin
              last_mean <= dneg ? -OUT_W'({qm[OUT_W-2:0], ge})
                                : OUT_W'({qm[OUT_W-2:0], ge});
            end
            addr      <= oldest;
            remaining <= held;
            acc       <= '0;
          end
        end
        S_WALK_SQ: begin
          sq        <= 50'(ad[24:0]) * 50'(ad[24:0]);
          addr      <= addr_inc;
          remaining <= remaining - 1'b1;
        end
        S_WALK_ACC: begin
          acc <= acc + ACC_W'(sq);
        end
        S_VAR_LOAD: begin
          dq    <= acc;
          drem  <= '0;
          ddiv  <= held;
          step  <= '0;
          dlast <= STEP_W'(ACC_W - 1);
        end
        S_SQRT_LOAD: begin
          sx   <= {1'b0, dq};
          sres <= '0;
          sbit <= (ACC_W+1)'(1) << (2 * (SQRT_STEPS - 1));
          step <= '0;
        end
        S_SQRT: begin
          if (sx >= st) begin
            sx   <= sx - st;
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
          step <= step + 1'b1;
          if (step == STEP_W'(SQRT_STEPS - 1)) begin
            res_dev  <= (sx >= st) ? OUT_W'((sres >> 1) + sbit) : OUT_W'(sres >> 1);
            last_dev <= (sx >= st) ? OUT_W'((sres >> 1) + sbit) : OUT_W'(sres >> 1);
          end
        end
        S_OUT: begin
          if (!out_valid || m_tready) begin
            out_valid <= 1'b1;
            out_data  <= {1'b0, held, res_dev, res_mean};
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### design/swms_checker.sv
// port-level checks for sliding_window_mean_stddev, bound to the top level
// uses the macros in sliding_window_mean_stddev_macros.svh
`include "sliding_window_mean_stddev_macros.svh"

module swms_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);

  // a stalled result stays put
  `SWMS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // held count never exceeds the largest window
  `SWMS_ASSERT_NOW(a_count_range, m_tvalid, m_tdata[54:48] <= 7'd64, "count above window max")

  // one request in work at a time
  `SWMS_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "ready right after a request")

endmodule

bind sliding_window_mean_stddev swms_checker u_swms_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
